### src/subenum_pkg.sv
`default_nettype none

package subenum_pkg;

    // Largest set handled; element and size fields are 5 bits wide
    localparam int MAX_SET = 16;
    localparam int IDX_W   = $clog2(MAX_SET);
    localparam int ELEM_W  = 5;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EMIT = 3'b010,
        ST_ADV  = 3'b100
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;      // request transaction accepted
        logic emit;       // load one result beat into the output register
        logic advance;    // step to the next subset
        logic cfg_write;  // write set_size and restart
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic done;       // every subset already emitted
        logic last_beat;  // current beat is the last of the subset
        logic out_free;   // output register can take a beat this cycle
    } dp_status_t;

endpackage

`default_nettype wire

### src/subset_enumerator.sv
// Lexicographic combination generator over {1..n}, sizes 1 to n in turn.
// A request is accepted in ST_IDLE; ST_EMIT then loads one beat per cycle into
// the output register while it is free, and ST_ADV steps to the next subset.
// An exhausted request emits a single beat; new requests wait for ST_IDLE.
// Reset: asynchronous, active low; n = 1, enumeration at subset {1}.
`default_nettype none

module subset_enumerator
    import subenum_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              restart,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ELEM_W-1:0] set_size,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ELEM_W-1:0]      element,
    output logic [ELEM_W-1:0]      subset_size,
    output logic                   last_of_subset,
    output logic                   exhausted
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Request sequencing
    subenum_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Index state and output register
    subenum_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .restart        (restart),
        .set_size       (set_size),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .element        (element),
        .subset_size    (subset_size),
        .last_of_subset (last_of_subset),
        .exhausted      (exhausted)
    );

endmodule

`default_nettype wire

### src/subenum_ctrl.sv
`default_nettype none

module subenum_ctrl
    import subenum_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence requests: accept (a config write wins), emit the run, advance unless exhausted
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        cfg_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.last_beat)
                    begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/subenum_dp.sv
`default_nettype none

module subenum_dp
    import subenum_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    input  wire logic              restart,
    input  wire logic [ELEM_W-1:0] set_size,
    output dp_status_t             status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ELEM_W-1:0]      element,
    output logic [ELEM_W-1:0]      subset_size,
    output logic                   last_of_subset,
    output logic                   exhausted
);

    logic [ELEM_W-1:0] set_size_reg;
    logic [IDX_W-1:0]  idx_reg [MAX_SET];
    logic [IDX_W-1:0]  idx_next [MAX_SET];
    logic [ELEM_W-1:0] cur_size_reg;
    logic [ELEM_W-1:0] cur_size_next;
    logic              done_reg;
    logic              done_next;
    logic [IDX_W-1:0]  k_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pivot_reg;
    logic [IDX_W-1:0]  pivot_val_reg;

    logic              out_valid_reg;
    logic [ELEM_W-1:0] element_reg;
    logic [ELEM_W-1:0] subset_size_reg;
    logic              last_reg;
    logic              exhausted_reg;

    logic [ELEM_W-1:0] n_eff;
    logic [ELEM_W-1:0] r_eff;
    logic [IDX_W-1:0]  idx_cur;
    logic [ELEM_W-1:0] grow_limit;
    logic              can_grow;
    logic              last_beat;
    logic              out_free;
    logic              start_over;

    // Clamp n to 1..MAX_SET and the size to n
    always_comb
    begin
        priority if (set_size_reg == '0)
        begin
            n_eff = ELEM_W'(1);
        end
        else if (set_size_reg > ELEM_W'(MAX_SET))
        begin
            n_eff = ELEM_W'(MAX_SET);
        end
        else
        begin
            n_eff = set_size_reg;
        end
        r_eff = (cur_size_reg > n_eff) ? n_eff : cur_size_reg;
    end

    // Current index and its pivot test: idx[k] < n - r + k
    assign idx_cur    = idx_reg[k_reg];
    assign grow_limit = n_eff - r_eff + ELEM_W'(k_reg);
    assign can_grow   = ELEM_W'(idx_cur) < grow_limit;
    assign last_beat  = (ELEM_W'(k_reg) + ELEM_W'(1)) == r_eff;
    assign out_free   = !out_valid_reg || out_ready;
    assign start_over = cmd.cfg_write || (cmd.start && restart);

    assign status.done      = done_reg;
    assign status.last_beat = last_beat;
    assign status.out_free  = out_free;

    // Next enumeration state
    always_comb
    begin
        for (int j = 0; j < MAX_SET; j++)
        begin
            idx_next[j] = idx_reg[j];
        end
        cur_size_next = cur_size_reg;
        done_next     = done_reg;
        if (start_over)
        begin
            for (int j = 0; j < MAX_SET; j++)
            begin
                idx_next[j] = IDX_W'(j);
            end
            cur_size_next = ELEM_W'(1);
            done_next     = 1'b0;
        end
        else if (cmd.advance)
        begin
            if (found_reg)
            begin
                // Bump the pivot and refill the tail with consecutive values
                for (int j = 0; j < MAX_SET; j++)
                begin
                    if ((ELEM_W'(j) >= ELEM_W'(pivot_reg)) && (ELEM_W'(j) < r_eff))
                    begin
                        idx_next[j] = IDX_W'(ELEM_W'(pivot_val_reg) + ELEM_W'(j)
                                      + ELEM_W'(1) - ELEM_W'(pivot_reg));
                    end
                end
            end
            else if (r_eff >= n_eff)
            begin
                done_next = 1'b1;
            end
            else
            begin
                cur_size_next = r_eff + ELEM_W'(1);
                for (int j = 0; j < MAX_SET; j++)
                begin
                    idx_next[j] = IDX_W'(j);
                end
            end
        end
    end

    // Enumeration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg <= ELEM_W'(1);
            for (int j = 0; j < MAX_SET; j++)
            begin
                idx_reg[j] <= IDX_W'(j);
            end
            cur_size_reg  <= ELEM_W'(1);
            done_reg      <= 1'b0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            pivot_reg     <= '0;
            pivot_val_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                set_size_reg <= set_size;
            end
            for (int j = 0; j < MAX_SET; j++)
            begin
                idx_reg[j] <= idx_next[j];
            end
            cur_size_reg <= cur_size_next;
            done_reg     <= done_next;
            if (cmd.start)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                k_reg <= k_reg + IDX_W'(1);
                // Rightmost growable index wins, as the scan is ascending
                if (can_grow)
                begin
                    found_reg     <= 1'b1;
                    pivot_reg     <= k_reg;
                    pivot_val_reg <= idx_cur;
                end
            end
        end
    end

    // Output register: load a beat, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            element_reg     <= '0;
            subset_size_reg <= '0;
            last_reg        <= 1'b0;
            exhausted_reg   <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
            if (done_reg)
            begin
                element_reg     <= '0;
                subset_size_reg <= '0;
                last_reg        <= 1'b0;
                exhausted_reg   <= 1'b1;
            end
            else
            begin
                element_reg     <= ELEM_W'(idx_cur) + ELEM_W'(1);
                subset_size_reg <= r_eff;
                last_reg        <= last_beat;
                exhausted_reg   <= 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign element        = element_reg;
    assign subset_size    = subset_size_reg;
    assign last_of_subset = last_reg;
    assign exhausted      = exhausted_reg;

endmodule

`default_nettype wire

### src/subenum_checker.sv
`default_nettype none

module subenum_checker
    import subenum_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [ELEM_W-1:0] element,
    input wire logic [ELEM_W-1:0] subset_size,
    input wire logic              last_of_subset,
    input wire logic              exhausted
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element)
            && $stable(subset_size) && $stable(last_of_subset) && $stable(exhausted))
        else $error("result beat changed while stalled");

    // An exhausted beat carries no element
    a_exh_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> element == '0 && subset_size == '0 && !last_of_subset)
        else $error("exhausted beat carries data");

    // A normal beat has its element and size within 1..MAX_SET
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !exhausted |-> element != '0 && subset_size != '0
            && element <= ELEM_W'(MAX_SET) && subset_size <= ELEM_W'(MAX_SET))
        else $error("element or size out of range");

    // Configuration write and request transaction never share an edge
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(in_valid && in_ready))
        else $error("configuration write during request transaction");

endmodule

bind subset_enumerator subenum_checker u_subenum_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element        (element),
    .subset_size    (subset_size),
    .last_of_subset (last_of_subset),
    .exhausted      (exhausted)
);

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import subenum_pkg::*;

    localparam int RUN_ITEMS   = 260;
    localparam int CALM_ITEMS  = 220;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [ELEM_W-1:0] subset_size;
        logic              last_of_subset;
        logic              exhausted;
    } beat_t;

    // Tracks the enumeration and holds the beats still to come
    class subset_tracker;
        logic [ELEM_W-1:0] size_reg;
        logic [IDX_W-1:0]  idx [MAX_SET];
        logic [ELEM_W-1:0] cur_size;
        bit                done;
        beat_t             pending_beats [$];
        int                errors;

        function new();
            size_reg = 5'd1;
            errors   = 0;
            start_over();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        function void start_over();
            for (int k = 0; k < MAX_SET; k++)
                idx[k] = IDX_W'(k);
            cur_size = 5'd1;
            done     = 1'b0;
        endfunction

        // Clamp the register into 1..MAX_SET
        function int eff_n();
            int n;
            n = int'(size_reg);
            if (n == 0) n = 1;
            if (n > MAX_SET) n = MAX_SET;
            return n;
        endfunction

        function void write_size(logic [ELEM_W-1:0] value);
            size_reg = value;
            start_over();
        endfunction

        // Step to the next combination, or the next size, or exhaustion
        function void step_forward(int n);
            int r;
            int i;
            bit found;
            r     = int'(cur_size);
            i     = r;
            found = 1'b0;
            while (i > 0 && !found)
            begin
                i--;
                if (int'(idx[i]) < n - r + i)
                    found = 1'b1;
            end
            if (found)
            begin
                idx[i] = idx[i] + IDX_W'(1);
                for (int j = i + 1; j < r; j++)
                    idx[j] = idx[j-1] + IDX_W'(1);
            end
            else if (r >= n)
            begin
                done = 1'b1;
            end
            else
            begin
                cur_size = ELEM_W'(r + 1);
                for (int k = 0; k < MAX_SET; k++)
                    idx[k] = IDX_W'(k);
            end
        endfunction

        // Queue the beats caused by one accepted request
        function void note_request(logic rst_req);
            int    n;
            int    r;
            beat_t b;
            n = eff_n();
            if (rst_req)
                start_over();
            if (done)
            begin
                b = '{element: '0, subset_size: '0, last_of_subset: 1'b0, exhausted: 1'b1};
                pending_beats.push_back(b);
                return;
            end
            r = int'(cur_size);
            if (r > n) r = n;
            for (int k = 0; k < r; k++)
            begin
                b.element        = ELEM_W'(int'(idx[k]) + 1);
                b.subset_size    = ELEM_W'(r);
                b.last_of_subset = (k + 1 == r);
                b.exhausted      = 1'b0;
                pending_beats.push_back(b);
            end
            step_forward(n);
        endfunction

        // Compare one accepted beat with the oldest expected one
        task check_beat(beat_t got);
            beat_t want;
            if (pending_beats.size() == 0)
            begin
                report($sformatf("unexpected beat elem=%0d size=%0d last=%0b exh=%0b",
                    got.element, got.subset_size, got.last_of_subset, got.exhausted));
                return;
            end
            want = pending_beats.pop_front();
            if (got.element !== want.element)
                report($sformatf("element got %0d want %0d", got.element, want.element));
            if (got.subset_size !== want.subset_size)
                report($sformatf("subset_size got %0d want %0d",
                    got.subset_size, want.subset_size));
            if (got.last_of_subset !== want.last_of_subset)
                report($sformatf("last_of_subset got %0b want %0b",
                    got.last_of_subset, want.last_of_subset));
            if (got.exhausted !== want.exhausted)
                report($sformatf("exhausted got %0b want %0b", got.exhausted, want.exhausted));
        endtask

        function int pending();
            return pending_beats.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              restart   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [ELEM_W-1:0] set_size  = 5'd1;
    logic              out_ready = 1'b0;
    logic              in_ready;
    logic              cfg_ready;
    logic              out_valid;
    logic [ELEM_W-1:0] element;
    logic [ELEM_W-1:0] subset_size;
    logic              last_of_subset;
    logic              exhausted;

    subset_tracker tracker = new();
    bit            calm    = 1'b0;
    int            cycles  = 0;
    int            sent    = 0;

    subset_enumerator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .set_size       (set_size),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .element        (element),
        .subset_size    (subset_size),
        .last_of_subset (last_of_subset),
        .exhausted      (exhausted)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_beat('{element: element, subset_size: subset_size,
                                 last_of_subset: last_of_subset, exhausted: exhausted});
    end

    // Stall the output side in random bursts until the calm tail
    initial
    begin
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Issue one request transaction and hold it until accepted
    task automatic send_request(logic rst_req);
        in_valid <= 1'b1;
        restart  <= rst_req;
        do @(posedge clk); while (!in_ready);
        tracker.note_request(rst_req);
        sent++;
    endtask

    // Drop valid for a random burst
    task automatic sender_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // Drop valid and wait until every expected beat has come
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    // Write set_size once the block has gone idle
    task automatic write_set_size(logic [ELEM_W-1:0] value);
        hold_until_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        set_size  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_size(value);
        cfg_valid <= 1'b0;
    endtask

    // Issue a request with a random gap in front of it
    task automatic paced_request(logic rst_req);
        if (!calm && $urandom_range(0, 3) == 0)
            sender_gap();
        send_request(rst_req);
    endtask

    initial
    begin
        int value;
        int len;
        int n;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: n = 1, then exhaustion and restart while exhausted
        paced_request(1'b0);
        paced_request(1'b0);
        paced_request(1'b0);
        paced_request(1'b1);
        paced_request(1'b0);

        // Walk n = 3 to the end, then restart from exhaustion
        write_set_size(5'd3);
        repeat (8) paced_request(1'b0);
        paced_request(1'b1);

        // Zero acts as one
        write_set_size(5'd0);
        paced_request(1'b0);
        paced_request(1'b0);

        // Above the maximum acts as the maximum
        write_set_size(5'd31);
        paced_request(1'b0);
        paced_request(1'b1);
        paced_request(1'b0);

        write_set_size(5'(MAX_SET));
        paced_request(1'b0);
        paced_request(1'b0);

        write_set_size(5'd2);
        repeat (4) paced_request(1'b0);

        // Random phases, mostly small n so that exhaustion is reached
        while (sent < RUN_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       value = $urandom_range(0, 31);
                1:       value = MAX_SET;
                default: value = $urandom_range(1, 5);
            endcase
            write_set_size(5'(value));
            n = (value == 0) ? 1 : ((value > MAX_SET) ? MAX_SET : value);
            len = (n <= 5) ? (1 << n) + $urandom_range(0, 4) : $urandom_range(5, 40);
            for (int k = 0; k < len && sent < RUN_ITEMS; k++)
            begin
                if (!calm && $urandom_range(0, 24) == 0)
                    hold_until_drained();
                paced_request($urandom_range(0, 15) == 0);
                if (sent >= CALM_ITEMS)
                    calm = 1'b1;
            end
        end

        // Drain and let the block settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/subenum_pkg.sv
src/subenum_ctrl.sv
src/subenum_dp.sv
src/subset_enumerator.sv
src/subenum_checker.sv
dv/tb_top.sv
